// File: hdl/ptcr_pkg.sv
// ----------------------------------------------------------------------------
// ptcr_pkg
// shared types and constants of the proportional text column renderer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptcr_pkg;

	// display and cursor geometry
	localparam int DISPLAY_COLUMNS_DEF = 32;
	localparam int CUR_W               = 6;    // cursor and start column width
	localparam int CNT_W               = 7;    // column counter, holds cursor plus glyph
	localparam int CUR_MAX             = 63;   // cursor saturates here

	// font
	localparam int CHAR_W      = 8;
	localparam int GLYPH_COLS  = 5;
	localparam int PIX_W       = 7;
	localparam int GW_W        = 3;
	localparam int FIRST_CODE  = 32;
	localparam int LAST_CODE   = 126;

	// input word layout, lowest bit first
	localparam int IN_TDATA_W  = 16;
	localparam int IN_CODE_LO  = 0;
	localparam int IN_START    = 8;
	localparam int IN_SCOL_LO  = 9;
	localparam int IN_NARROW   = 15;

	typedef struct packed {
		logic [GW_W-1:0]                  width;
		logic [GLYPH_COLS-1:0][PIX_W-1:0] cols;    // cols[0] is the leftmost column
	} glyph_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_GLYPH,
		S_BLANK,
		S_END,
		S_FLUSH
	} seq_state_t;

endpackage

// File: hdl/ptcr_glyph_rom.sv
// ----------------------------------------------------------------------------
// ptcr_glyph_rom
// proportional font table, 95 glyphs, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptcr_glyph_rom
	import ptcr_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [CHAR_W-1:0] code,
	output glyph_t            glyph
);

	// top bit of each byte has no row and is dropped
	function automatic glyph_t mk(input logic [GW_W-1:0] w, input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
		input logic [7:0] b4);
		glyph_t g;
		g.width   = w;
		g.cols[0] = b0[PIX_W-1:0];
		g.cols[1] = b1[PIX_W-1:0];
		g.cols[2] = b2[PIX_W-1:0];
		g.cols[3] = b3[PIX_W-1:0];
		g.cols[4] = b4[PIX_W-1:0];
		return g;
	endfunction

	function automatic glyph_t font(input logic [CHAR_W-1:0] c);
		glyph_t g;
		case (c)
			8'd32:  g = mk(3'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd33:  g = mk(3'd1, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd34:  g = mk(3'd3, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00);
			8'd35:  g = mk(3'd5, 8'h14, 8'h3E, 8'h14, 8'h3E, 8'h14);
			8'd36:  g = mk(3'd4, 8'h24, 8'h6A, 8'h2B, 8'h12, 8'h00);
			8'd37:  g = mk(3'd5, 8'h63, 8'h13, 8'h08, 8'h64, 8'h63);
			8'd38:  g = mk(3'd5, 8'h36, 8'h49, 8'h56, 8'h20, 8'h50);
			8'd39:  g = mk(3'd1, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd40:  g = mk(3'd3, 8'h1C, 8'h22, 8'h41, 8'h00, 8'h00);
			8'd41:  g = mk(3'd3, 8'h41, 8'h22, 8'h1C, 8'h00, 8'h00);
			8'd42:  g = mk(3'd5, 8'h28, 8'h18, 8'h0E, 8'h18, 8'h28);
			8'd43:  g = mk(3'd5, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
			8'd44:  g = mk(3'd2, 8'hB0, 8'h70, 8'h00, 8'h00, 8'h00);
			8'd45:  g = mk(3'd4, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00);
			8'd46:  g = mk(3'd2, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00);
			8'd47:  g = mk(3'd4, 8'h60, 8'h18, 8'h06, 8'h01, 8'h00);
			8'd48:  g = mk(3'd4, 8'h3E, 8'h41, 8'h41, 8'h3E, 8'h00);
			8'd49:  g = mk(3'd3, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00);
			8'd50:  g = mk(3'd4, 8'h62, 8'h51, 8'h49, 8'h46, 8'h00);
			8'd51:  g = mk(3'd4, 8'h22, 8'h41, 8'h49, 8'h36, 8'h00);
			8'd52:  g = mk(3'd4, 8'h18, 8'h14, 8'h12, 8'h7F, 8'h00);
			8'd53:  g = mk(3'd4, 8'h27, 8'h45, 8'h45, 8'h39, 8'h00);
			8'd54:  g = mk(3'd4, 8'h3E, 8'h49, 8'h49, 8'h30, 8'h00);
			8'd55:  g = mk(3'd4, 8'h61, 8'h11, 8'h09, 8'h07, 8'h00);
			8'd56:  g = mk(3'd4, 8'h36, 8'h49, 8'h49, 8'h36, 8'h00);
			8'd57:  g = mk(3'd4, 8'h06, 8'h49, 8'h49, 8'h3E, 8'h00);
			8'd58:  g = mk(3'd2, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd59:  g = mk(3'd2, 8'h80, 8'h50, 8'h00, 8'h00, 8'h00);
			8'd60:  g = mk(3'd3, 8'h10, 8'h28, 8'h44, 8'h00, 8'h00);
			8'd61:  g = mk(3'd3, 8'h14, 8'h14, 8'h14, 8'h00, 8'h00);
			8'd62:  g = mk(3'd3, 8'h44, 8'h28, 8'h10, 8'h00, 8'h00);
			8'd63:  g = mk(3'd4, 8'h02, 8'h59, 8'h09, 8'h06, 8'h00);
			8'd64:  g = mk(3'd5, 8'h3E, 8'h49, 8'h55, 8'h5D, 8'h0E);
			8'd65:  g = mk(3'd4, 8'h7E, 8'h11, 8'h11, 8'h7E, 8'h00);
			8'd66:  g = mk(3'd4, 8'h7F, 8'h49, 8'h49, 8'h36, 8'h00);
			8'd67:  g = mk(3'd4, 8'h3E, 8'h41, 8'h41, 8'h22, 8'h00);
			8'd68:  g = mk(3'd4, 8'h7F, 8'h41, 8'h41, 8'h3E, 8'h00);
			8'd69:  g = mk(3'd4, 8'h7F, 8'h49, 8'h49, 8'h41, 8'h00);
			8'd70:  g = mk(3'd4, 8'h7F, 8'h09, 8'h09, 8'h01, 8'h00);
			8'd71:  g = mk(3'd4, 8'h3E, 8'h41, 8'h49, 8'h7A, 8'h00);
			8'd72:  g = mk(3'd4, 8'h7F, 8'h08, 8'h08, 8'h7F, 8'h00);
			8'd73:  g = mk(3'd3, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00);
			8'd74:  g = mk(3'd4, 8'h30, 8'h40, 8'h41, 8'h3F, 8'h00);
			8'd75:  g = mk(3'd4, 8'h7F, 8'h08, 8'h14, 8'h63, 8'h00);
			8'd76:  g = mk(3'd4, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h00);
			8'd77:  g = mk(3'd5, 8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
			8'd78:  g = mk(3'd5, 8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
			8'd79:  g = mk(3'd4, 8'h3E, 8'h41, 8'h41, 8'h3E, 8'h00);
			8'd80:  g = mk(3'd4, 8'h7F, 8'h09, 8'h09, 8'h06, 8'h00);
			8'd81:  g = mk(3'd4, 8'h3E, 8'h41, 8'h41, 8'hBE, 8'h00);
			8'd82:  g = mk(3'd4, 8'h7F, 8'h09, 8'h09, 8'h76, 8'h00);
			8'd83:  g = mk(3'd4, 8'h46, 8'h49, 8'h49, 8'h32, 8'h00);
			8'd84:  g = mk(3'd5, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
			8'd85:  g = mk(3'd4, 8'h3F, 8'h40, 8'h40, 8'h3F, 8'h00);
			8'd86:  g = mk(3'd5, 8'h0F, 8'h30, 8'h40, 8'h30, 8'h0F);
			8'd87:  g = mk(3'd5, 8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
			8'd88:  g = mk(3'd5, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
			8'd89:  g = mk(3'd5, 8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
			8'd90:  g = mk(3'd4, 8'h61, 8'h51, 8'h49, 8'h47, 8'h00);
			8'd91:  g = mk(3'd2, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h00);
			8'd92:  g = mk(3'd4, 8'h01, 8'h06, 8'h18, 8'h60, 8'h00);
			8'd93:  g = mk(3'd2, 8'h41, 8'h7F, 8'h00, 8'h00, 8'h00);
			8'd94:  g = mk(3'd3, 8'h02, 8'h01, 8'h02, 8'h00, 8'h00);
			8'd95:  g = mk(3'd4, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00);
			8'd96:  g = mk(3'd2, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00);
			8'd97:  g = mk(3'd4, 8'h20, 8'h54, 8'h54, 8'h78, 8'h00);
			8'd98:  g = mk(3'd4, 8'h7F, 8'h44, 8'h44, 8'h38, 8'h00);
			8'd99:  g = mk(3'd4, 8'h38, 8'h44, 8'h44, 8'h28, 8'h00);
			8'd100: g = mk(3'd4, 8'h38, 8'h44, 8'h44, 8'h7F, 8'h00);
			8'd101: g = mk(3'd4, 8'h38, 8'h54, 8'h54, 8'h18, 8'h00);
			8'd102: g = mk(3'd3, 8'h04, 8'h7E, 8'h05, 8'h00, 8'h00);
			8'd103: g = mk(3'd4, 8'h98, 8'hA4, 8'hA4, 8'h78, 8'h00);
			8'd104: g = mk(3'd4, 8'h7F, 8'h04, 8'h04, 8'h78, 8'h00);
			8'd105: g = mk(3'd3, 8'h44, 8'h7D, 8'h40, 8'h00, 8'h00);
			8'd106: g = mk(3'd4, 8'h40, 8'h80, 8'h84, 8'h7D, 8'h00);
			8'd107: g = mk(3'd4, 8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
			8'd108: g = mk(3'd3, 8'h41, 8'h7F, 8'h40, 8'h00, 8'h00);
			8'd109: g = mk(3'd5, 8'h7C, 8'h04, 8'h7C, 8'h04, 8'h78);
			8'd110: g = mk(3'd4, 8'h7C, 8'h04, 8'h04, 8'h78, 8'h00);
			8'd111: g = mk(3'd4, 8'h38, 8'h44, 8'h44, 8'h38, 8'h00);
			8'd112: g = mk(3'd4, 8'hFC, 8'h24, 8'h24, 8'h18, 8'h00);
			8'd113: g = mk(3'd4, 8'h18, 8'h24, 8'h24, 8'hFC, 8'h00);
			8'd114: g = mk(3'd4, 8'h7C, 8'h08, 8'h04, 8'h04, 8'h00);
			8'd115: g = mk(3'd4, 8'h48, 8'h54, 8'h54, 8'h24, 8'h00);
			8'd116: g = mk(3'd3, 8'h04, 8'h3F, 8'h44, 8'h00, 8'h00);
			8'd117: g = mk(3'd4, 8'h3C, 8'h40, 8'h40, 8'h7C, 8'h00);
			8'd118: g = mk(3'd5, 8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
			8'd119: g = mk(3'd5, 8'h3C, 8'h40, 8'h3C, 8'h40, 8'h3C);
			8'd120: g = mk(3'd5, 8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
			8'd121: g = mk(3'd4, 8'h9C, 8'hA0, 8'hA0, 8'h7C, 8'h00);
			8'd122: g = mk(3'd3, 8'h64, 8'h54, 8'h4C, 8'h00, 8'h00);
			8'd123: g = mk(3'd5, 8'h10, 8'h20, 8'h60, 8'h18, 8'h06);
			8'd124: g = mk(3'd1, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd125: g = mk(3'd3, 8'h41, 8'h36, 8'h08, 8'h00, 8'h00);
			8'd126: g = mk(3'd4, 8'h08, 8'h04, 8'h08, 8'h04, 8'h00);
			default: g = mk(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		endcase
		return g;
	endfunction

	always_ff @(posedge clk) begin
		if (rd_en) begin
			glyph <= font(code);
		end
	end

endmodule

// File: hdl/proportional_text_column_renderer.sv
// ----------------------------------------------------------------------------
// proportional_text_column_renderer
// turns a character stream into column writes for a row of led matrix chips
// ----------------------------------------------------------------------------
// One input word carries one character of a text. The block answers with
// the column writes it causes, one output word per column: first the
// clearing of the columns left of the start column (when text_start is
// set), then the glyph columns and one blank column, then the clearing of
// the columns from the cursor to the right edge (when tlast is set). The
// last write of each input word carries tlast; an input word may cause no
// write at all. Writes to columns at or beyond DISPLAY_COLUMNS are dropped
// but still move the cursor. Codes outside 32 to 126 are ignored. The block
// takes one input word at a time: a single column counter steps the
// sequencer one column per cycle while the output side does not stall.
// A word goes through its accept, the start clear columns, the glyph
// columns (w = 1 to 5), the blank column, the end clear columns, the
// phase changes and the final hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module proportional_text_column_renderer
	import ptcr_pkg::*;
#(
	parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
	localparam int COL_W   = $clog2(DISPLAY_COLUMNS),
	localparam int DEV_W   = (COL_W > 3) ? COL_W - 3 : 1,
	localparam int OUT_RAW = COL_W + DEV_W + 3 + PIX_W,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// char_code[7:0], text_start[8], start_column[14:9], narrow_spacing[15]
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	// char_present
	input  logic                  s_axis_tuser,
	// text_end
	input  logic                  s_axis_tlast,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// display_column, device_index, device_column, pixels, zero pad
	output logic [OUT_W-1:0]      m_axis_tdata,
	// clear_whole
	output logic                  m_axis_tuser,
	// last_of_run
	output logic                  m_axis_tlast
);

	localparam logic [CNT_W-1:0] DC_CNT  = CNT_W'(DISPLAY_COLUMNS);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(CUR_MAX);
	localparam logic [CUR_W-1:0] MAX_CUR = CUR_W'(CUR_MAX);

	// input field split
	logic [CHAR_W-1:0] in_code;
	logic              in_start;
	logic [CUR_W-1:0]  in_scol;
	logic              in_narrow;
	logic              in_accept;
	logic              in_glyph_ok;

	assign in_code   = s_axis_tdata[IN_CODE_LO +: CHAR_W];
	assign in_start  = s_axis_tdata[IN_START];
	assign in_scol   = s_axis_tdata[IN_SCOL_LO +: CUR_W];
	assign in_narrow = s_axis_tdata[IN_NARROW];

	// sequencer state
	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] col_q, col_d;        // the shared column counter
	logic [GW_W-1:0]  gidx_q, gidx_d;      // glyph column index
	logic [CUR_W-1:0] cursor_q, cursor_d;
	logic             stopped_q, stopped_d;

	// per word registers, loaded on accept
	logic             start_q;
	logic [CUR_W-1:0] scol_q;
	logic             narrow_q;
	logic             end_q;
	logic             glyph_ok_q;
	glyph_t           glyph;

	// one pending write ahead of the output register, so the last one can be marked
	logic             hold_v_q;
	logic [COL_W-1:0] hold_col_q;
	logic             hold_clr_q;
	logic [PIX_W-1:0] hold_pix_q;

	logic             out_v_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_clr_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_last_q;

	// write produced by the sequencer this cycle
	logic             emit;
	logic             emit_clr;
	logic [PIX_W-1:0] emit_pix;
	logic             out_free;
	logic             stall;
	logic             push;
	logic             flush_move;
	logic [CNT_W-1:0] col_inc;
	logic [CUR_W-1:0] col_sat;
	logic [CUR_W-1:0] blank_next;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// a start word clears the stopped flag before the character is judged
	assign in_glyph_ok = s_axis_tuser && (in_start || !stopped_q)
		&& (in_code >= CHAR_W'(FIRST_CODE)) && (in_code <= CHAR_W'(LAST_CODE));

	ptcr_glyph_rom u_rom (
		.clk   (clk),
		.rd_en (in_accept),
		.code  (in_code),
		.glyph (glyph)
	);

	assign out_free = !out_v_q || m_axis_tready;
	assign stall    = emit && hold_v_q && !out_free;
	assign push     = emit && !stall;

	// the one incrementer shared by every column phase, and the cursor saturation
	assign col_inc    = col_q + CNT_W'(1);
	assign col_sat    = (col_q > MAX_CNT) ? MAX_CUR : col_q[CUR_W-1:0];
	assign blank_next = narrow_q ? cursor_q
		: ((col_inc > MAX_CNT) ? MAX_CUR : col_inc[CUR_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			gidx_q    <= '0;
			cursor_q  <= '0;
			stopped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			col_q     <= col_d;
			gidx_q    <= gidx_d;
			cursor_q  <= cursor_d;
			stopped_q <= stopped_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		gidx_d     = gidx_q;
		cursor_d   = cursor_q;
		stopped_d  = stopped_q;
		emit       = 1'b0;
		emit_clr   = 1'b1;
		emit_pix   = '0;
		flush_move = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					col_d   = '0;
					state_d = S_START;
					if (in_start) begin
						cursor_d  = in_scol;
						stopped_d = 1'b0;
					end
				end
			end
			// clear columns left of the start column
			S_START: begin
				if (start_q && (col_q < {1'b0, scol_q}) && (col_q < DC_CNT)) begin
					emit = 1'b1;
					if (!stall) begin
						col_d = col_inc;
					end
				end else begin
					col_d   = {1'b0, cursor_q};
					gidx_d  = '0;
					state_d = glyph_ok_q ? S_GLYPH : S_END;
				end
			end
			// glyph columns; off-edge ones still step the counter but write nothing
			S_GLYPH: begin
				if (gidx_q < glyph.width) begin
					emit     = (col_q < DC_CNT);
					emit_clr = 1'b0;
					emit_pix = glyph.cols[gidx_q];
					if (!stall) begin
						col_d  = col_inc;
						gidx_d = gidx_q + GW_W'(1);
					end
				end else begin
					cursor_d = col_sat;
					col_d    = {1'b0, col_sat};
					state_d  = S_BLANK;
				end
			end
			// blank column after the glyph, then the spacing advance
			S_BLANK: begin
				emit = (col_q < DC_CNT);
				if (!stall) begin
					cursor_d  = blank_next;
					col_d     = {1'b0, blank_next};
					stopped_d = ({1'b0, blank_next} > DC_CNT);
					state_d   = S_END;
				end
			end
			// clear from the cursor to the right edge
			S_END: begin
				if (end_q && (col_q < DC_CNT)) begin
					emit = 1'b1;
					if (!stall) begin
						col_d = col_inc;
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			// hand the pending write over as the last of the run
			S_FLUSH: begin
				if (!hold_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					flush_move = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// word registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			start_q    <= in_start;
			scol_q     <= in_scol;
			narrow_q   <= in_narrow;
			end_q      <= s_axis_tlast;
			glyph_ok_q <= in_glyph_ok;
		end
	end

	// pending write and output register valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				hold_v_q <= 1'b1;
			end else if (flush_move) begin
				hold_v_q <= 1'b0;
			end
			if ((push && hold_v_q) || flush_move) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_col_q <= col_q[COL_W-1:0];
			hold_clr_q <= emit_clr;
			hold_pix_q <= emit_pix;
		end
		if ((push && hold_v_q) || flush_move) begin
			out_col_q  <= hold_col_q;
			out_clr_q  <= hold_clr_q;
			out_pix_q  <= hold_pix_q;
			out_last_q <= flush_move;
		end
	end

	// chip index is the column over eight, chip column is mirrored within the chip
	logic [DEV_W-1:0] out_dev;
	logic [2:0]       out_dcol;

	assign out_dev       = DEV_W'(out_col_q >> 3);
	assign out_dcol      = ~out_col_q[2:0];
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_W'({out_pix_q, out_dcol, out_dev, out_col_q});
	assign m_axis_tuser  = out_clr_q;
	assign m_axis_tlast  = out_last_q;

	// no write may be left pending while a new word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_v_q)
		else $error("pending write left over when idle");

	// clear writes carry no pixels
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_clr_q) |-> (out_pix_q == '0))
		else $error("clear write with pixels set");

	// a stopped text keeps its cursor past the edge
	assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> ({1'b0, cursor_q} > DC_CNT))
		else $error("stopped flag with cursor inside the display");

	// every write stays inside the display
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (CNT_W'(out_col_q) < DC_CNT))
		else $error("write beyond the display edge");

endmodule

// File: verif/proportional_text_column_renderer_test.sv
// ----------------------------------------------------------------------------
// proportional_text_column_renderer_test
// self-checking bench for the proportional text column renderer
// ----------------------------------------------------------------------------
// Characters are sent as input words, and each accepted word runs through a
// column-level model of the renderer. That model keeps its own cursor, its
// stopped flag and a copy of the font. The column writes it predicts queue
// up in order. Every output word is compared field by field with the oldest
// write in that queue. Directed tests cover the extremes first. Random texts
// follow under three idle patterns on the two stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module proportional_text_column_renderer_test;
	import ptcr_pkg::*;

	localparam int NCOLS       = DISPLAY_COLUMNS_DEF;
	localparam int OUT_W       = 24;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN       = 40;      // extra wait after the last predicted write

	// one expected column write, fields in output order
	typedef struct packed {
		logic [4:0] col;
		logic [1:0] dev;
		logic [2:0] dcol;
		logic       clr;
		logic [6:0] pix;
		logic       last;
	} col_write_t;

	logic              clk;
	logic              arst_n         = 1'b0;
	logic              s_axis_tvalid  = 1'b0;
	logic              s_axis_tready;
	// char_code[7:0], text_start[8], start_column[14:9], narrow_spacing[15]
	logic [15:0]       s_axis_tdata   = '0;
	// char_present
	logic              s_axis_tuser   = 1'b0;
	// text_end
	logic              s_axis_tlast   = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready  = 1'b0;
	// display_column[4:0], device_index[6:5], device_column[9:7], pixels[16:10]
	logic [OUT_W-1:0]  m_axis_tdata;
	// clear_whole
	logic              m_axis_tuser;
	// last_of_run
	logic              m_axis_tlast;

	// model state
	int                cursor_col;
	bit                text_halted;
	col_write_t        held_write;
	bit                have_held;
	col_write_t        pending_writes[$];

	int                error_count;
	int                cycle_count;
	int                tx_idle_pct;
	int                rx_idle_pct;

	proportional_text_column_renderer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// font, indexed by code: width, then five column bytes, left column first
	function automatic logic [47:0] glyph_bits(input logic [7:0] code);
		logic [47:0] g;
		case (code)
			8'd32:  g = 48'h03_00_00_00_00_00;  8'd33:  g = 48'h01_5F_00_00_00_00;
			8'd34:  g = 48'h03_03_00_03_00_00;  8'd35:  g = 48'h05_14_3E_14_3E_14;
			8'd36:  g = 48'h04_24_6A_2B_12_00;  8'd37:  g = 48'h05_63_13_08_64_63;
			8'd38:  g = 48'h05_36_49_56_20_50;  8'd39:  g = 48'h01_03_00_00_00_00;
			8'd40:  g = 48'h03_1C_22_41_00_00;  8'd41:  g = 48'h03_41_22_1C_00_00;
			8'd42:  g = 48'h05_28_18_0E_18_28;  8'd43:  g = 48'h05_08_08_3E_08_08;
			8'd44:  g = 48'h02_B0_70_00_00_00;  8'd45:  g = 48'h04_08_08_08_08_00;
			8'd46:  g = 48'h02_60_60_00_00_00;  8'd47:  g = 48'h04_60_18_06_01_00;
			8'd48:  g = 48'h04_3E_41_41_3E_00;  8'd49:  g = 48'h03_42_7F_40_00_00;
			8'd50:  g = 48'h04_62_51_49_46_00;  8'd51:  g = 48'h04_22_41_49_36_00;
			8'd52:  g = 48'h04_18_14_12_7F_00;  8'd53:  g = 48'h04_27_45_45_39_00;
			8'd54:  g = 48'h04_3E_49_49_30_00;  8'd55:  g = 48'h04_61_11_09_07_00;
			8'd56:  g = 48'h04_36_49_49_36_00;  8'd57:  g = 48'h04_06_49_49_3E_00;
			8'd58:  g = 48'h02_50_00_00_00_00;  8'd59:  g = 48'h02_80_50_00_00_00;
			8'd60:  g = 48'h03_10_28_44_00_00;  8'd61:  g = 48'h03_14_14_14_00_00;
			8'd62:  g = 48'h03_44_28_10_00_00;  8'd63:  g = 48'h04_02_59_09_06_00;
			8'd64:  g = 48'h05_3E_49_55_5D_0E;  8'd65:  g = 48'h04_7E_11_11_7E_00;
			8'd66:  g = 48'h04_7F_49_49_36_00;  8'd67:  g = 48'h04_3E_41_41_22_00;
			8'd68:  g = 48'h04_7F_41_41_3E_00;  8'd69:  g = 48'h04_7F_49_49_41_00;
			8'd70:  g = 48'h04_7F_09_09_01_00;  8'd71:  g = 48'h04_3E_41_49_7A_00;
			8'd72:  g = 48'h04_7F_08_08_7F_00;  8'd73:  g = 48'h03_41_7F_41_00_00;
			8'd74:  g = 48'h04_30_40_41_3F_00;  8'd75:  g = 48'h04_7F_08_14_63_00;
			8'd76:  g = 48'h04_7F_40_40_40_00;  8'd77:  g = 48'h05_7F_02_0C_02_7F;
			8'd78:  g = 48'h05_7F_04_08_10_7F;  8'd79:  g = 48'h04_3E_41_41_3E_00;
			8'd80:  g = 48'h04_7F_09_09_06_00;  8'd81:  g = 48'h04_3E_41_41_BE_00;
			8'd82:  g = 48'h04_7F_09_09_76_00;  8'd83:  g = 48'h04_46_49_49_32_00;
			8'd84:  g = 48'h05_01_01_7F_01_01;  8'd85:  g = 48'h04_3F_40_40_3F_00;
			8'd86:  g = 48'h05_0F_30_40_30_0F;  8'd87:  g = 48'h05_3F_40_38_40_3F;
			8'd88:  g = 48'h05_63_14_08_14_63;  8'd89:  g = 48'h05_07_08_70_08_07;
			8'd90:  g = 48'h04_61_51_49_47_00;  8'd91:  g = 48'h02_7F_41_00_00_00;
			8'd92:  g = 48'h04_01_06_18_60_00;  8'd93:  g = 48'h02_41_7F_00_00_00;
			8'd94:  g = 48'h03_02_01_02_00_00;  8'd95:  g = 48'h04_40_40_40_40_00;
			8'd96:  g = 48'h02_01_02_00_00_00;  8'd97:  g = 48'h04_20_54_54_78_00;
			8'd98:  g = 48'h04_7F_44_44_38_00;  8'd99:  g = 48'h04_38_44_44_28_00;
			8'd100: g = 48'h04_38_44_44_7F_00;  8'd101: g = 48'h04_38_54_54_18_00;
			8'd102: g = 48'h03_04_7E_05_00_00;  8'd103: g = 48'h04_98_A4_A4_78_00;
			8'd104: g = 48'h04_7F_04_04_78_00;  8'd105: g = 48'h03_44_7D_40_00_00;
			8'd106: g = 48'h04_40_80_84_7D_00;  8'd107: g = 48'h04_7F_10_28_44_00;
			8'd108: g = 48'h03_41_7F_40_00_00;  8'd109: g = 48'h05_7C_04_7C_04_78;
			8'd110: g = 48'h04_7C_04_04_78_00;  8'd111: g = 48'h04_38_44_44_38_00;
			8'd112: g = 48'h04_FC_24_24_18_00;  8'd113: g = 48'h04_18_24_24_FC_00;
			8'd114: g = 48'h04_7C_08_04_04_00;  8'd115: g = 48'h04_48_54_54_24_00;
			8'd116: g = 48'h03_04_3F_44_00_00;  8'd117: g = 48'h04_3C_40_40_7C_00;
			8'd118: g = 48'h05_1C_20_40_20_1C;  8'd119: g = 48'h05_3C_40_3C_40_3C;
			8'd120: g = 48'h05_44_28_10_28_44;  8'd121: g = 48'h04_9C_A0_A0_7C_00;
			8'd122: g = 48'h03_64_54_4C_00_00;  8'd123: g = 48'h05_10_20_60_18_06;
			8'd124: g = 48'h01_7F_00_00_00_00;  8'd125: g = 48'h03_41_36_08_00_00;
			8'd126: g = 48'h04_08_04_08_04_00;
			default: g = '0;
		endcase
		return g;
	endfunction

	// cursor stops counting at the top of its range
	function automatic int cursor_add(input int a, input int b);
		return (a + b > CUR_MAX) ? CUR_MAX : a + b;
	endfunction

	// one write is held back so the final one of a word can get its last flag
	task automatic stage_write(input int col, input bit clr, input logic [6:0] pix);
		col_write_t w;
		if (col < NCOLS) begin
			w.col  = col[4:0];
			w.dev  = col[4:3];
			w.dcol = 3'd7 - col[2:0];
			w.clr  = clr;
			w.pix  = clr ? 7'd0 : pix;
			w.last = 1'b0;
			if (have_held)
				pending_writes.push_back(held_write);
			held_write = w;
			have_held  = 1'b1;
		end
	endtask

	// column writes caused by one character word
	task automatic render_char(input logic [7:0] code, input logic present,
			input logic text_first, input logic [5:0] scol, input logic narrow,
			input logic text_last);
		logic [47:0] g;
		int          w;
		int          c;
		if (text_first) begin
			for (c = 0; c < scol && c < NCOLS; c++)
				stage_write(c, 1'b1, 7'd0);
			cursor_col  = int'(scol);
			text_halted = 1'b0;
		end
		if (present && !text_halted && code >= FIRST_CODE && code <= LAST_CODE) begin
			g = glyph_bits(code);
			w = int'(g[47:40]);
			// glyph bit 7 has no row, only the low seven bits go out
			for (c = 0; c < w; c++)
				stage_write(cursor_col + c, 1'b0, g[38 - 8 * c -: 7]);
			cursor_col = cursor_add(cursor_col, w);
			stage_write(cursor_col, 1'b1, 7'd0);
			if (!narrow)
				cursor_col = cursor_add(cursor_col, 1);
			if (cursor_col > NCOLS)
				text_halted = 1'b1;
		end
		if (text_last) begin
			for (c = cursor_col; c < NCOLS; c++)
				stage_write(c, 1'b1, 7'd0);
		end
		if (have_held) begin
			held_write.last = 1'b1;
			pending_writes.push_back(held_write);
			have_held = 1'b0;
		end
	endtask

	// drive one word, wait for its handshake, then predict its writes;
	// called and left at a rising edge, tvalid stays high on return
	task automatic send_char(input logic [7:0] code, input logic present,
			input logic text_first, input logic [5:0] scol, input logic narrow,
			input logic text_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {narrow, scol, text_first, code};
		s_axis_tuser  <= present;
		s_axis_tlast  <= text_last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		render_char(code, present, text_first, scol, narrow, text_last);
	endtask

	// receiver side back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	// compare every accepted output word with the oldest prediction
	always @(posedge clk) begin : check_writes
		col_write_t seen;
		col_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tdata[4:0], m_axis_tdata[6:5], m_axis_tdata[9:7],
				m_axis_tuser, m_axis_tdata[16:10], m_axis_tlast};
			if (pending_writes.size() == 0) begin
				$display("%0t: expected no write, actual col %0d clr %0d pix %h last %0d",
					$time, seen.col, seen.clr, seen.pix, seen.last);
				error_count++;
			end else begin
				want = pending_writes.pop_front();
				if (seen !== want) begin
					$write("%0t: expected col %0d dev %0d dcol %0d clr %0d pix %h last %0d,",
						$time, want.col, want.dev, want.dcol, want.clr, want.pix,
						want.last);
					$display(" actual col %0d dev %0d dcol %0d clr %0d pix %h last %0d",
						seen.col, seen.dev, seen.dcol, seen.clr, seen.pix, seen.last);
					error_count++;
				end
			end
		end
	end

	// watchdog on a hung handshake
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// codes around both ends of the font, with ignored codes between and after them
	task automatic test_code_range;
		send_char(8'd32,  1'b1, 1'b1, 6'd0, 1'b0, 1'b0);
		send_char(8'd0,   1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
		send_char(8'd31,  1'b1, 1'b0, 6'd63, 1'b0, 1'b0);
		send_char(8'd126, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0);
		send_char(8'd127, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
		send_char(8'd255, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0);
		// ignored code still clears to the right edge
		send_char(8'd200, 1'b1, 1'b0, 6'd0, 1'b0, 1'b1);
	endtask

	task automatic test_clearing;
		// empty text: left clear and right clear only
		send_char(8'd65,  1'b0, 1'b1, 6'd5,  1'b0, 1'b1);
		// start on the edge, the glyph lands off the display
		send_char(8'd65,  1'b1, 1'b1, 6'd32, 1'b0, 1'b1);
		// start past the edge
		send_char(8'd72,  1'b0, 1'b1, 6'd33, 1'b1, 1'b1);
		// start at the top, the cursor saturates
		send_char(8'd87,  1'b1, 1'b1, 6'd63, 1'b0, 1'b1);
		// widest run: full glyph at 0, narrow blank, clear to the edge
		send_char(8'd77,  1'b1, 1'b1, 6'd0,  1'b1, 1'b1);
	endtask

	// glyph columns with bit 7 set
	task automatic test_glyph_bit_seven;
		send_char(8'd44,  1'b1, 1'b1, 6'd0, 1'b0, 1'b0);
		send_char(8'd103, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
		send_char(8'd81,  1'b1, 1'b0, 6'd0, 1'b1, 1'b1);
	endtask

	task automatic test_spacing_and_stop;
		// narrow blank and first right-clear column on the same spot
		send_char(8'd77,  1'b1, 1'b1, 6'd10, 1'b1, 1'b1);
		// text runs off the edge, further characters are dropped
		send_char(8'd87,  1'b1, 1'b1, 6'd28, 1'b0, 1'b0);
		send_char(8'd87,  1'b1, 1'b0, 6'd0,  1'b0, 1'b0);
		send_char(8'd65,  1'b1, 1'b0, 6'd0,  1'b0, 1'b0);
		send_char(8'd66,  1'b1, 1'b0, 6'd0,  1'b0, 1'b1);
		// text spread over words without a new start
		send_char(8'd72,  1'b1, 1'b1, 6'd0,  1'b0, 1'b0);
		send_char(8'd105, 1'b1, 1'b0, 6'd0,  1'b0, 1'b0);
		send_char(8'd33,  1'b1, 1'b0, 6'd0,  1'b1, 1'b1);
		send_char(8'd108, 1'b1, 1'b0, 6'd0,  1'b0, 1'b1);
	endtask

	// mostly well-formed texts, with noise words in between
	task automatic test_random_texts(input int n_items);
		int          sent;
		int          len;
		int          k;
		int          pick;
		logic [7:0]  code;
		logic [5:0]  scol;
		logic [5:0]  word_scol;
		logic        narrow;
		logic        present;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 80) begin
				len    = $urandom_range(8, 1);
				narrow = 1'($urandom_range(1));
				pick   = $urandom_range(99);
				if (pick < 70)
					scol = 6'($urandom_range(24, 0));
				else if (pick < 90)
					scol = 6'($urandom_range(32, 25));
				else
					scol = 6'($urandom_range(63, 33));
				for (k = 0; k < len; k++) begin
					code    = ($urandom_range(99) < 88) ? 8'($urandom_range(126, 32))
						: 8'($urandom_range(255, 0));
					present = ($urandom_range(99) < 95);
					if ($urandom_range(99) < 10)
						narrow = ~narrow;
					// start column bits are don't-care past the first word
					word_scol = (k == 0) ? scol : 6'($urandom_range(63, 0));
					send_char(code, present, k == 0, word_scol, narrow, k == len - 1);
					sent++;
				end
			end else begin
				code    = 8'($urandom_range(255, 0));
				present = 1'($urandom_range(1));
				scol    = 6'($urandom_range(63, 0));
				send_char(code, present, 1'($urandom_range(1)), scol,
					1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		error_count = 0;
		cursor_col  = 0;
		text_halted = 1'b0;
		have_held   = 1'b0;
		tx_idle_pct = 12;
		rx_idle_pct = 67;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_code_range();
		test_clearing();
		test_glyph_bit_seven();
		test_spacing_and_stop();
		test_random_texts(160);

		// sender now idles more than the receiver
		tx_idle_pct = 67;
		rx_idle_pct = 12;
		test_random_texts(160);

		// back to back on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_texts(150);

		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
